>>> sv/ssdm_pkg.sv
package ssdm_pkg;

  localparam int DigitCount = 4;
  localparam int ScanIdxW   = 2;
  localparam int InDataW    = 64;
  localparam int OutDataW   = 16;

  typedef enum logic [1:0] {
    REQ_NUMBER = 2'd0,
    REQ_CHARS  = 2'd1,
    REQ_MIXED  = 2'd2,
    REQ_TICK   = 2'd3
  } req_e;

  typedef logic [7:0] glyph_t;
  typedef glyph_t [DigitCount-1:0] glyph_buf_t;

  localparam glyph_t GlyphBlank = 8'hFF;
  localparam glyph_t DpBit      = 8'h80;

  typedef struct packed {
    req_e        req_type;
    logic [15:0] number;
    logic [7:0]  lead_char;
    logic [7:0]  char_left;
    logic [7:0]  char_mid_left;
    logic [7:0]  char_mid_right;
    logic [7:0]  char_right;
    logic [7:0]  dot_pos;
  } item_t;

endpackage

>>> sv/ssdm_enc.sv
module ssdm_enc (
  input  ssdm_pkg::item_t      item_i,
  output ssdm_pkg::glyph_buf_t glyphs_o
);

  function automatic ssdm_pkg::glyph_t dec_glyph(input logic [3:0] d);
    ssdm_pkg::glyph_t g;
    case (d)
      4'd0:    g = 8'hC0;
      4'd1:    g = 8'hF9;
      4'd2:    g = 8'hA4;
      4'd3:    g = 8'hB0;
      4'd4:    g = 8'h99;
      4'd5:    g = 8'h92;
      4'd6:    g = 8'h82;
      4'd7:    g = 8'hF8;
      4'd8:    g = 8'h80;
      4'd9:    g = 8'h90;
      default: g = ssdm_pkg::GlyphBlank;
    endcase
    return g;
  endfunction

  function automatic ssdm_pkg::glyph_t char_glyph(input logic [7:0] c);
    ssdm_pkg::glyph_t g;
    case (c)
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34,
      8'h35, 8'h36, 8'h37, 8'h38, 8'h39: g = dec_glyph(c[3:0]);
      8'h41:   g = 8'h88; // A
      8'h42:   g = 8'h83; // B
      8'h43:   g = 8'hC6; // C
      8'h44:   g = 8'hA1; // D
      8'h45:   g = 8'h86; // E
      8'h46:   g = 8'h8E; // F
      8'h50:   g = 8'h8C; // P
      8'h55:   g = 8'hC1; // U
      8'h59:   g = 8'h91; // Y
      8'h4C:   g = 8'hC7; // L
      8'h2A:   g = 8'h00; // all lit
      8'h23:   g = 8'hFF; // blank
      8'h2D:   g = 8'hBF; // middle bar
      8'h24:   g = 8'h8F; // segments e, f, g
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  // reciprocal multiplies, exact for values below 10000
  function automatic logic [9:0] div10(input logic [13:0] x);
    logic [29:0] p;
    p = 30'(x) * 30'd52429;
    return p[28:19];
  endfunction

  function automatic logic [6:0] div100(input logic [13:0] x);
    logic [26:0] p;
    p = 27'(x) * 27'd5243;
    return p[25:19];
  endfunction

  function automatic logic [3:0] div1000(input logic [13:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'd8389;
    return p[26:23];
  endfunction

  logic [13:0] val;
  logic [9:0]  tens;
  logic [6:0]  hund;
  logic [3:0]  thou;
  logic [3:0]  n_d0, n_d1, n_d2;
  logic [13:0] low8;
  logic [9:0]  tens8;
  logic [6:0]  hund8;
  logic [3:0]  m_d0, m_d1, m_d2;
  ssdm_pkg::glyph_buf_t loaded;

  // number modulo 10000 by picking the largest multiple that fits
  always_comb begin
    if (item_i.number >= 16'd60000)      val = 14'(item_i.number - 16'd60000);
    else if (item_i.number >= 16'd50000) val = 14'(item_i.number - 16'd50000);
    else if (item_i.number >= 16'd40000) val = 14'(item_i.number - 16'd40000);
    else if (item_i.number >= 16'd30000) val = 14'(item_i.number - 16'd30000);
    else if (item_i.number >= 16'd20000) val = 14'(item_i.number - 16'd20000);
    else if (item_i.number >= 16'd10000) val = 14'(item_i.number - 16'd10000);
    else                                 val = item_i.number[13:0];
  end

  assign tens = div10(val);
  assign hund = div100(val);
  assign thou = div1000(val);
  assign n_d0 = 4'(val - 14'(tens) * 14'd10);
  assign n_d1 = 4'(tens - 10'(hund) * 10'd10);
  assign n_d2 = 4'(hund - 7'(thou) * 7'd10);

  assign low8  = {6'b0, item_i.number[7:0]};
  assign tens8 = div10(low8);
  assign hund8 = div100(low8);
  assign m_d0  = 4'(low8 - 14'(tens8) * 14'd10);
  assign m_d1  = 4'(tens8 - 10'(hund8) * 10'd10);
  assign m_d2  = hund8[3:0];

  always_comb begin
    case (item_i.req_type)
      ssdm_pkg::REQ_NUMBER: begin
        loaded[0] = dec_glyph(n_d0);
        loaded[1] = dec_glyph(n_d1);
        loaded[2] = dec_glyph(n_d2);
        loaded[3] = dec_glyph(thou);
      end
      ssdm_pkg::REQ_CHARS: begin
        loaded[0] = char_glyph(item_i.char_right);
        loaded[1] = char_glyph(item_i.char_mid_right);
        loaded[2] = char_glyph(item_i.char_mid_left);
        loaded[3] = char_glyph(item_i.char_left);
      end
      default: begin
        loaded[0] = dec_glyph(m_d0);
        loaded[1] = dec_glyph(m_d1);
        loaded[2] = dec_glyph(m_d2);
        loaded[3] = char_glyph(item_i.lead_char);
      end
    endcase
  end

  always_comb begin
    glyphs_o = loaded;
    if (item_i.dot_pos[7:2] == 6'd0) begin
      glyphs_o[item_i.dot_pos[1:0]] = loaded[item_i.dot_pos[1:0]] ^ ssdm_pkg::DpBit;
    end
  end

endmodule

>>> sv/seven_segment_display_mux.sv
// four-digit multiplexed seven-segment display driver (common anode)
// input stream: tuser carries the request kind (0 number, 1 four characters,
// 2 character plus three digits, 3 scan tick); tdata carries the operands.
// update transactions rewrite the four-entry glyph buffer and give no output.
// a scan tick steps the scan index, then sends one output transaction with the
// active-low digit enable and that digit's active-low segment pattern.
// a transaction is held in the input register; a tick's result is then
// registered in the output register.
// throughput: one transaction per cycle while no tick is blocked, set by the
// single decode stage between the input register and the glyph buffer.
// when the output receiver stalls, a tick waits in the input register and
// s_axis_tready_o drops; updates keep flowing until a tick is blocked.
// reset blanks all four glyphs (0xff), clears the scan index to zero and
// empties both registers; the first tick after reset drives scan index one.
module seven_segment_display_mux (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // number[15:0], lead_char[23:16], char_left[31:24], char_mid_left[39:32],
  // char_mid_right[47:40], char_right[55:48], dot_pos[63:56]
  input  logic [63:0] s_axis_tdata_i,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // digit_enable[3:0], segments[11:4], zero[15:12]
  output logic [15:0] m_axis_tdata_o
);

  logic                 in_valid_q;
  ssdm_pkg::item_t      in_item_q;
  ssdm_pkg::item_t      in_item_d;
  ssdm_pkg::glyph_buf_t buf_q;
  ssdm_pkg::glyph_buf_t buf_new;
  logic [ssdm_pkg::ScanIdxW-1:0] scan_q, scan_d;
  logic                 out_valid_q;
  logic [15:0]          out_data_q, out_data_d;
  logic                 out_free, is_tick, advance, in_take;

  assign in_item_d.req_type       = ssdm_pkg::req_e'(s_axis_tuser_i);
  assign in_item_d.number         = s_axis_tdata_i[15:0];
  assign in_item_d.lead_char      = s_axis_tdata_i[23:16];
  assign in_item_d.char_left      = s_axis_tdata_i[31:24];
  assign in_item_d.char_mid_left  = s_axis_tdata_i[39:32];
  assign in_item_d.char_mid_right = s_axis_tdata_i[47:40];
  assign in_item_d.char_right     = s_axis_tdata_i[55:48];
  assign in_item_d.dot_pos        = s_axis_tdata_i[63:56];

  ssdm_enc u_enc (
    .item_i   (in_item_q),
    .glyphs_o (buf_new)
  );

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign is_tick  = (in_item_q.req_type == ssdm_pkg::REQ_TICK);
  // updates never wait; a tick waits for room in the output register
  assign advance  = in_valid_q && (!is_tick || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take  = s_axis_tvalid_i && s_axis_tready_o;

  assign scan_d = scan_q + 2'd1;
  assign out_data_d = {4'b0, buf_q[~scan_d], ~(4'b0001 << scan_d)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      scan_q      <= '0;
      buf_q       <= {ssdm_pkg::DigitCount{ssdm_pkg::GlyphBlank}};
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance && is_tick) begin
        out_valid_q <= 1'b1;
        scan_q      <= scan_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance && !is_tick) begin
        buf_q <= buf_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_d;
    end
    if (advance && is_tick) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
